FILE: src/amts_pkg.sv
// Package for the APB master transfer sequencer.
// Holds widths, operation, phase and completion codes, and the queue entry type.
// No dependencies.
package amts_pkg;

   localparam int ADDR_W = 32;
   localparam int DATA_W = 32;
   localparam int TMO_W  = 20;
   localparam int STRB_W = DATA_W / 8;
   localparam int PROT_W = 3;

   localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(1000);

   // queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // request function codes as seen on the port
   localparam logic [1:0] FUNC_TICK   = 2'd0;
   localparam logic [1:0] FUNC_READ   = 2'd1;
   localparam logic [1:0] FUNC_WRITE  = 2'd2;
   localparam logic [1:0] FUNC_SWRITE = 2'd3;

   // classified operation
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // bus phases
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_SETUP  = 2'd1;
   localparam logic [1:0] PH_ACCESS = 2'd2;

   // completion codes
   localparam logic [2:0] CPL_NONE    = 3'd0;
   localparam logic [2:0] CPL_OK      = 3'd1;
   localparam logic [2:0] CPL_SLVERR  = 3'd2;
   localparam logic [2:0] CPL_TIMEOUT = 3'd3;
   localparam logic [2:0] CPL_BUSY    = 3'd4;

   typedef struct packed {
      logic [1:0]        op;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
      logic [STRB_W-1:0] strobe;
      logic [PROT_W-1:0] prot;
      logic              bus_ready;
      logic              xfer_done;
      logic              slv_err;
      logic [DATA_W-1:0] rdata;
   } cmd_type;

endpackage

FILE: src/amts_front.sv
// Front end: classifies an incoming transfer into a queue entry.
// Depends on amts_pkg.
module amts_front (
   input  logic [1:0]                  req_func,
   input  logic [amts_pkg::ADDR_W-1:0] req_address,
   input  logic [amts_pkg::DATA_W-1:0] req_write_data,
   input  logic [amts_pkg::STRB_W-1:0] req_byte_strobe,
   input  logic [amts_pkg::PROT_W-1:0] req_protection,
   input  logic                        req_bus_ready,
   input  logic                        req_transfer_done,
   input  logic                        req_slave_error,
   input  logic [amts_pkg::DATA_W-1:0] req_read_data_in,
   output amts_pkg::cmd_type           cmd
);
   import amts_pkg::*;

   always_comb begin
      cmd           = '0;
      cmd.addr      = req_address;
      cmd.prot      = req_protection;
      cmd.bus_ready = req_bus_ready;
      cmd.xfer_done = req_transfer_done;
      cmd.slv_err   = req_slave_error;
      cmd.rdata     = req_read_data_in;
      unique case (req_func)
         FUNC_TICK: begin
            cmd.op = OP_TICK;
         end
         FUNC_READ: begin
            // reads drive no strobes and zero data
            cmd.op = OP_READ;
         end
         FUNC_WRITE: begin
            cmd.op     = OP_WRITE;
            cmd.wdata  = req_write_data;
            cmd.strobe = '1;
         end
         FUNC_SWRITE: begin
            cmd.op     = OP_WRITE;
            cmd.wdata  = req_write_data;
            cmd.strobe = req_byte_strobe;
         end
         default: begin
            cmd.op = OP_TICK;
         end
      endcase
   end

endmodule

FILE: src/amts_queue.sv
// Short FIFO of classified transfers between front and back end.
// Depends on amts_pkg.
module amts_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  amts_pkg::cmd_type push_cmd,
   input  logic              pop,
   output amts_pkg::cmd_type head_cmd,
   output logic              empty,
   output logic              full
);
   import amts_pkg::*;

   cmd_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == QCNT_W'(QDEPTH));
   assign head_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count out of range");

endmodule

FILE: src/amts_back.sv
// Back end: APB phase sequencer with wait timeout and registered result stage.
// Depends on amts_pkg.
module amts_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [amts_pkg::TMO_W-1:0]  csr_wr_data,
   input  amts_pkg::cmd_type           cmd,
   input  logic                        cmd_avail,
   output logic                        cmd_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_phase,
   output logic [amts_pkg::ADDR_W-1:0] rsp_out_addr,
   output logic                        rsp_out_is_write,
   output logic [amts_pkg::PROT_W-1:0] rsp_out_prot,
   output logic [amts_pkg::STRB_W-1:0] rsp_out_strobe,
   output logic [amts_pkg::DATA_W-1:0] rsp_out_wdata,
   output logic                        rsp_out_enable,
   output logic [2:0]                  rsp_completion,
   output logic [amts_pkg::DATA_W-1:0] rsp_read_data_out,
   output logic                        rsp_error_flag
);
   import amts_pkg::*;

   logic [TMO_W-1:0]  timeout_ff;
   logic [1:0]        phase_ff, phase_in;
   logic [TMO_W-1:0]  wait_ff, wait_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              write_ff, write_in;
   logic [PROT_W-1:0] prot_ff, prot_in;
   logic [STRB_W-1:0] strobe_ff, strobe_in;
   logic [DATA_W-1:0] wdata_ff, wdata_in;
   logic              err_ff, err_in;
   logic [2:0]        cpl_in;
   logic [DATA_W-1:0] rdata_in;

   logic              valid_ff;
   logic [1:0]        o_phase_ff;
   logic [ADDR_W-1:0] o_addr_ff;
   logic              o_write_ff;
   logic [PROT_W-1:0] o_prot_ff;
   logic [STRB_W-1:0] o_strobe_ff;
   logic [DATA_W-1:0] o_wdata_ff;
   logic              o_enable_ff;
   logic [2:0]        o_cpl_ff;
   logic [DATA_W-1:0] o_rdata_ff;
   logic              o_err_ff;

   // take the next entry whenever the result stage is free or draining
   assign cmd_pop = cmd_avail && (!valid_ff || !rsp_stall);

   always_comb begin
      phase_in  = phase_ff;
      wait_in   = wait_ff;
      addr_in   = addr_ff;
      write_in  = write_ff;
      prot_in   = prot_ff;
      strobe_in = strobe_ff;
      wdata_in  = wdata_ff;
      err_in    = err_ff;
      cpl_in    = CPL_NONE;
      rdata_in  = '0;
      if (cmd.op != OP_TICK) begin
         if (phase_ff != PH_IDLE) begin
            cpl_in = CPL_BUSY;
         end else begin
            addr_in   = cmd.addr;
            prot_in   = cmd.prot;
            write_in  = (cmd.op == OP_WRITE);
            strobe_in = cmd.strobe;
            wdata_in  = cmd.wdata;
            phase_in  = PH_SETUP;
            wait_in   = timeout_ff;
         end
      end else if (phase_ff == PH_SETUP) begin
         if (cmd.bus_ready) begin
            phase_in = PH_ACCESS;
            wait_in  = timeout_ff;
         end else if (wait_ff == '0) begin
            phase_in = PH_IDLE;
            err_in   = 1'b1;
            cpl_in   = CPL_TIMEOUT;
         end else begin
            wait_in = wait_ff - 1'b1;
         end
      end else if (phase_ff == PH_ACCESS) begin
         if (cmd.xfer_done) begin
            err_in   = cmd.slv_err;
            phase_in = PH_IDLE;
            if (!cmd.slv_err) begin
               cpl_in = CPL_OK;
               if (!write_ff) begin
                  rdata_in = cmd.rdata;
               end
            end else begin
               cpl_in = CPL_SLVERR;
            end
         end else if (wait_ff == '0) begin
            phase_in = PH_IDLE;
            err_in   = 1'b1;
            cpl_in   = CPL_TIMEOUT;
         end else begin
            wait_in = wait_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TMO_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= (csr_wr_data == '0) ? TMO_W'(1) : csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         wait_ff   <= '0;
         addr_ff   <= '0;
         write_ff  <= 1'b0;
         prot_ff   <= '0;
         strobe_ff <= '1;
         wdata_ff  <= '0;
         err_ff    <= 1'b0;
      end else if (cmd_pop) begin
         phase_ff  <= phase_in;
         wait_ff   <= wait_in;
         addr_ff   <= addr_in;
         write_ff  <= write_in;
         prot_ff   <= prot_in;
         strobe_ff <= strobe_in;
         wdata_ff  <= wdata_in;
         err_ff    <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd_pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         o_phase_ff  <= phase_in;
         o_addr_ff   <= addr_in;
         o_write_ff  <= write_in;
         o_prot_ff   <= prot_in;
         o_strobe_ff <= strobe_in;
         o_wdata_ff  <= (phase_in == PH_ACCESS) ? wdata_in : '0;
         o_enable_ff <= (phase_in == PH_ACCESS);
         o_cpl_ff    <= cpl_in;
         o_rdata_ff  <= rdata_in;
         o_err_ff    <= err_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_phase         = o_phase_ff;
   assign rsp_out_addr      = o_addr_ff;
   assign rsp_out_is_write  = o_write_ff;
   assign rsp_out_prot      = o_prot_ff;
   assign rsp_out_strobe    = o_strobe_ff;
   assign rsp_out_wdata     = o_wdata_ff;
   assign rsp_out_enable    = o_enable_ff;
   assign rsp_completion    = o_cpl_ff;
   assign rsp_read_data_out = o_rdata_ff;
   assign rsp_error_flag    = o_err_ff;

   a_tmo_nonzero: assert property (@(posedge clock) disable iff (reset)
      timeout_ff != '0)
      else $error("timeout register is zero");
   a_busy_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd.op != OP_TICK && phase_ff != PH_IDLE)
      |=> (phase_ff == $past(phase_ff) && o_cpl_ff == CPL_BUSY))
      else $error("request while busy disturbed the sequencer");
   a_timeout_idles: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cpl_in == CPL_TIMEOUT) |=> (phase_ff == PH_IDLE && err_ff))
      else $error("timeout did not return to idle with error");
   a_rdata_only_ok_read: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && o_rdata_ff != '0) |-> (o_cpl_ff == CPL_OK && !o_write_ff))
      else $error("read data returned outside a good read");

endmodule

FILE: src/apb_master_transfer_sequencer.sv
// Top level of the APB master transfer sequencer.
// Depends on amts_pkg, amts_front, amts_queue, amts_back.
//
// Usage:
//  - req_* channel: one transfer per item. func 1/2/3 starts a read, write or
//    strobed write (only while the bus is idle, else completion is "rejected
//    busy"); func 0 is a bus tick that samples ready, done, error, read data.
//  - rsp_* channel: exactly one result per accepted item, in order: phase,
//    driven bus attributes, completion code, read data and sticky error flag.
//  - csr_*: write of the per-phase timeout in ticks; zero is taken as one.
//    Only write while no transfer is in flight.
//  - Flow: the accepting edge writes the item into the queue; once the result
//    register is free or draining, the sequencer takes the item from the queue
//    and registers its result in the result register. Throughput: one item per
//    clock while the rsp side does not stall.
//  - A stalled rsp side holds the result register; the queue (two entries)
//    absorbs in-flight items, and req_stall rises only when it is full.
//  - Reset: synchronous, active high. Phase idle, timeout 1000, strobes all
//    ones, other held attributes and the error flag cleared, queue empty.
module apb_master_transfer_sequencer (
   input  logic                        clock,
   input  logic                        reset,
   // configuration
   input  logic                        csr_wr_en,
   input  logic [amts_pkg::TMO_W-1:0]  csr_wr_data,
   // request transfers
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_func,
   input  logic [amts_pkg::ADDR_W-1:0] req_address,
   input  logic [amts_pkg::DATA_W-1:0] req_write_data,
   input  logic [amts_pkg::STRB_W-1:0] req_byte_strobe,
   input  logic [amts_pkg::PROT_W-1:0] req_protection,
   input  logic                        req_bus_ready,
   input  logic                        req_transfer_done,
   input  logic                        req_slave_error,
   input  logic [amts_pkg::DATA_W-1:0] req_read_data_in,
   // result transfers
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_phase,
   output logic [amts_pkg::ADDR_W-1:0] rsp_out_addr,
   output logic                        rsp_out_is_write,
   output logic [amts_pkg::PROT_W-1:0] rsp_out_prot,
   output logic [amts_pkg::STRB_W-1:0] rsp_out_strobe,
   output logic [amts_pkg::DATA_W-1:0] rsp_out_wdata,
   output logic                        rsp_out_enable,
   output logic [2:0]                  rsp_completion,
   output logic [amts_pkg::DATA_W-1:0] rsp_read_data_out,
   output logic                        rsp_error_flag
);
   import amts_pkg::*;

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    q_push;
   logic    q_pop;
   logic    q_empty;
   logic    q_full;

   // front accepts whenever the queue has room
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   amts_front u_front (
      .req_func          (req_func),
      .req_address       (req_address),
      .req_write_data    (req_write_data),
      .req_byte_strobe   (req_byte_strobe),
      .req_protection    (req_protection),
      .req_bus_ready     (req_bus_ready),
      .req_transfer_done (req_transfer_done),
      .req_slave_error   (req_slave_error),
      .req_read_data_in  (req_read_data_in),
      .cmd               (front_cmd)
   );

   amts_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (front_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   // back end runs the APB phases and owns the result register
   amts_back u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .cmd               (head_cmd),
      .cmd_avail         (!q_empty),
      .cmd_pop           (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_phase         (rsp_phase),
      .rsp_out_addr      (rsp_out_addr),
      .rsp_out_is_write  (rsp_out_is_write),
      .rsp_out_prot      (rsp_out_prot),
      .rsp_out_strobe    (rsp_out_strobe),
      .rsp_out_wdata     (rsp_out_wdata),
      .rsp_out_enable    (rsp_out_enable),
      .rsp_completion    (rsp_completion),
      .rsp_read_data_out (rsp_read_data_out),
      .rsp_error_flag    (rsp_error_flag)
   );

endmodule

FILE: tb/apb_master_transfer_sequencer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for apb_master_transfer_sequencer: a directed table, then random
// transfers under bursty sender and stalling receiver. Depends on amts_pkg and the RTL only.
module apb_master_transfer_sequencer_test;
   import amts_pkg::*;

   // Slowest correct run: ~1670 transfers, each with a short random sender gap plus receiver
   // stall (the queue is two deep), plus bus settling and drains around every timeout write.
   // CYCLE_LIMIT is set above that.
   localparam int CYCLE_LIMIT     = 400000;
   localparam int REPORT_LIMIT    = 10;
   localparam int RAND_PHASES     = 8;
   localparam int ITEMS_PER_PHASE = 203;

   // one request-side transfer, field for field as on the req_ ports
   typedef struct packed {
      logic [1:0]        func;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
      logic [STRB_W-1:0] strobe;
      logic [PROT_W-1:0] prot;
      logic              ready;
      logic              done;
      logic              serr;
      logic [DATA_W-1:0] rdata;
   } apb_req_type;

   // what the bus looks like after one transfer, as on the rsp_ ports
   typedef struct packed {
      logic [1:0]        phase;
      logic [ADDR_W-1:0] addr;
      logic              is_write;
      logic [PROT_W-1:0] prot;
      logic [STRB_W-1:0] strobe;
      logic [DATA_W-1:0] wdata;
      logic              enable;
      logic [2:0]        cpl;
      logic [DATA_W-1:0] rdata;
      logic              err;
   } bus_view_type;

   // directed table row: either a timeout write or a transfer, the latter optionally
   // with its bus view typed in
   typedef struct packed {
      logic              is_csr;
      logic [TMO_W-1:0]  csr_value;
      logic              typed;
      apb_req_type       req;
      bus_view_type      view;
   } dir_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [TMO_W-1:0]    csr_wr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_func = FUNC_TICK;
   logic [ADDR_W-1:0]   req_address = '0;
   logic [DATA_W-1:0]   req_write_data = '0;
   logic [STRB_W-1:0]   req_byte_strobe = '0;
   logic [PROT_W-1:0]   req_protection = '0;
   logic                req_bus_ready = 1'b0;
   logic                req_transfer_done = 1'b0;
   logic                req_slave_error = 1'b0;
   logic [DATA_W-1:0]   req_read_data_in = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_phase;
   logic [ADDR_W-1:0]   rsp_out_addr;
   logic                rsp_out_is_write;
   logic [PROT_W-1:0]   rsp_out_prot;
   logic [STRB_W-1:0]   rsp_out_strobe;
   logic [DATA_W-1:0]   rsp_out_wdata;
   logic                rsp_out_enable;
   logic [2:0]          rsp_completion;
   logic [DATA_W-1:0]   rsp_read_data_out;
   logic                rsp_error_flag;

   // shadow copy of the sequencer: phase, countdown, latched attributes, sticky error
   logic [1:0]          seq_phase;
   logic [TMO_W-1:0]    seq_wait;
   logic [TMO_W-1:0]    seq_timeout;
   logic [ADDR_W-1:0]   seq_addr;
   logic                seq_write;
   logic [PROT_W-1:0]   seq_prot;
   logic [STRB_W-1:0]   seq_strobe;
   logic [DATA_W-1:0]   seq_wdata;
   logic                seq_err;

   bus_view_type        bus_views_due[$];
   dir_row_type         dir_rows[$];

   int cycle_count = 0;
   int mismatch_count = 0;
   int checked_count = 0;
   int sent_count = 0;
   int ok_count = 0;
   int slverr_count = 0;
   int timeout_count = 0;
   int busy_count = 0;
   int tmo_writes = 0;
   int burst_left = 0;
   int stall_left = 0;
   int stall_mode = 0;

   apb_master_transfer_sequencer dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_address       (req_address),
      .req_write_data    (req_write_data),
      .req_byte_strobe   (req_byte_strobe),
      .req_protection    (req_protection),
      .req_bus_ready     (req_bus_ready),
      .req_transfer_done (req_transfer_done),
      .req_slave_error   (req_slave_error),
      .req_read_data_in  (req_read_data_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_phase         (rsp_phase),
      .rsp_out_addr      (rsp_out_addr),
      .rsp_out_is_write  (rsp_out_is_write),
      .rsp_out_prot      (rsp_out_prot),
      .rsp_out_strobe    (rsp_out_strobe),
      .rsp_out_wdata     (rsp_out_wdata),
      .rsp_out_enable    (rsp_out_enable),
      .rsp_completion    (rsp_completion),
      .rsp_read_data_out (rsp_read_data_out),
      .rsp_error_flag    (rsp_error_flag)
   );

   always #5 clock = ~clock;

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count,
                  bus_views_due.size());
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic string view_text(bus_view_type v);
      return $sformatf({"phase=%0d addr=%h wr=%b prot=%0d strb=%h wdata=%h en=%b cpl=%0d ",
                        "rdata=%h err=%b"}, v.phase, v.addr, v.is_write, v.prot, v.strobe,
                       v.wdata, v.enable, v.cpl, v.rdata, v.err);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Sequencer prediction. One transfer in, the bus view after it out; the shadow state moves.
   // ---------------------------------------------------------------------------------------
   task automatic advance_sequencer(input apb_req_type r, output bus_view_type v);
      logic [2:0]        cpl;
      logic [DATA_W-1:0] rd;
      cpl = CPL_NONE;
      rd  = '0;
      if (r.func != FUNC_TICK) begin
         // a request only starts a transfer from idle; otherwise it bounces, state untouched
         if (seq_phase != PH_IDLE) begin
            cpl = CPL_BUSY;
         end else begin
            seq_addr = r.addr;
            seq_prot = r.prot;
            if (r.func == FUNC_READ) begin
               // reads drive no strobes and no write data
               seq_write  = 1'b0;
               seq_strobe = '0;
               seq_wdata  = '0;
            end else begin
               seq_write  = 1'b1;
               seq_strobe = (r.func == FUNC_SWRITE) ? r.strobe : '1;
               seq_wdata  = r.wdata;
            end
            seq_phase = PH_SETUP;
            seq_wait  = seq_timeout;
         end
      end else if (seq_phase == PH_SETUP) begin
         if (r.ready) begin
            seq_phase = PH_ACCESS;
            seq_wait  = seq_timeout;
         end else if (seq_wait == '0) begin
            seq_phase = PH_IDLE;
            seq_err   = 1'b1;
            cpl       = CPL_TIMEOUT;
         end else begin
            seq_wait--;
         end
      end else if (seq_phase == PH_ACCESS) begin
         if (r.done) begin
            // slave error is sticky until the next completion; read data only on success
            seq_err = r.serr;
            if (!r.serr) begin
               cpl = CPL_OK;
               if (!seq_write) rd = r.rdata;
            end else begin
               cpl = CPL_SLVERR;
            end
            seq_phase = PH_IDLE;
         end else if (seq_wait == '0) begin
            seq_phase = PH_IDLE;
            seq_err   = 1'b1;
            cpl       = CPL_TIMEOUT;
         end else begin
            seq_wait--;
         end
      end
      // a tick while idle falls through: nothing changes
      case (cpl)
         CPL_OK:      ok_count++;
         CPL_SLVERR:  slverr_count++;
         CPL_TIMEOUT: timeout_count++;
         CPL_BUSY:    busy_count++;
         default:     ;
      endcase
      v.phase    = seq_phase;
      v.addr     = seq_addr;
      v.is_write = seq_write;
      v.prot     = seq_prot;
      v.strobe   = seq_strobe;
      v.wdata    = (seq_phase == PH_ACCESS) ? seq_wdata : '0;
      v.enable   = (seq_phase == PH_ACCESS);
      v.cpl      = cpl;
      v.rdata    = rd;
      v.err      = seq_err;
   endtask

   // ---------------------------------------------------------------------------------------
   // Request side. Inputs move on the falling edge; acceptance is seen at the rising edge.
   // The sender runs in bursts of random length with random gaps in between.
   // ---------------------------------------------------------------------------------------
   task automatic drive_transfer(input apb_req_type r, input logic typed,
                                 input bus_view_type typed_view);
      int           gap;
      bus_view_type v;
      @(negedge clock);
      if (burst_left == 0) begin
         // a third of bursts start back to back, the rest after a short gap
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_func          <= r.func;
      req_address       <= r.addr;
      req_write_data    <= r.wdata;
      req_byte_strobe   <= r.strobe;
      req_protection    <= r.prot;
      req_bus_ready     <= r.ready;
      req_transfer_done <= r.done;
      req_slave_error   <= r.serr;
      req_read_data_in  <= r.rdata;
      req_valid         <= 1'b1;
      // payload held until the transfer goes through
      do @(posedge clock); while (req_stall);
      sent_count++;
      advance_sequencer(r, v);
      bus_views_due.push_back(typed ? typed_view : v);
   endtask

   // stop sending and let every due result come back, then let the pipe settle
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (bus_views_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // timeout register write: only with the bus idle and nothing in flight
   task automatic write_timeout(input logic [TMO_W-1:0] value);
      apb_req_type r;
      // finish any open transfer with ready/done ticks (slave error chosen at random)
      while (seq_phase != PH_IDLE) begin
         r       = '0;
         r.func  = FUNC_TICK;
         r.ready = 1'b1;
         r.done  = 1'b1;
         r.serr  = 1'($urandom_range(0, 1));
         r.rdata = $urandom;
         drive_transfer(r, 1'b0, '0);
      end
      quiesce();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      // zero is taken as one
      seq_timeout = (value == '0) ? TMO_W'(1) : value;
      tmo_writes++;
   endtask

   // ---------------------------------------------------------------------------------------
   // Result side. The receiver stalls on its own pattern; every accepted result is checked
   // against the oldest due bus view.
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 80);
      end
      stall_left--;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;                        // free running
         1:       rsp_stall <= ($urandom_range(0, 3) == 0); // light
         2:       rsp_stall <= ($urandom_range(0, 3) != 0); // heavy
         default: rsp_stall <= ((cycle_count % 7) < 4);     // periodic runs
      endcase
   end

   always @(posedge clock) begin : check_results
      bus_view_type got;
      bus_view_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.phase    = rsp_phase;
         got.addr     = rsp_out_addr;
         got.is_write = rsp_out_is_write;
         got.prot     = rsp_out_prot;
         got.strobe   = rsp_out_strobe;
         got.wdata    = rsp_out_wdata;
         got.enable   = rsp_out_enable;
         got.cpl      = rsp_completion;
         got.rdata    = rsp_read_data_out;
         got.err      = rsp_error_flag;
         checked_count++;
         if (bus_views_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("cycle %0d: result with no transfer due: %s", cycle_count,
                        view_text(got));
         end else begin
            want = bus_views_due.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("cycle %0d: result %0d differs", cycle_count, checked_count);
                  $display("   expected %s", view_text(want));
                  $display("   actual   %s", view_text(got));
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Directed table rows
   // ---------------------------------------------------------------------------------------
   function automatic dir_row_type xfer(input logic [1:0] func, input logic [ADDR_W-1:0] addr,
                                        input logic [DATA_W-1:0] wdata,
                                        input logic [STRB_W-1:0] strobe,
                                        input logic [PROT_W-1:0] prot, input logic ready,
                                        input logic done, input logic serr,
                                        input logic [DATA_W-1:0] rdata);
      dir_row_type row;
      row            = '0;
      row.req.func   = func;
      row.req.addr   = addr;
      row.req.wdata  = wdata;
      row.req.strobe = strobe;
      row.req.prot   = prot;
      row.req.ready  = ready;
      row.req.done   = done;
      row.req.serr   = serr;
      row.req.rdata  = rdata;
      return row;
   endfunction

   function automatic bus_view_type view(input logic [1:0] phase,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic is_write, input logic [PROT_W-1:0] prot,
                                         input logic [STRB_W-1:0] strobe,
                                         input logic [DATA_W-1:0] wdata, input logic enable,
                                         input logic [2:0] cpl,
                                         input logic [DATA_W-1:0] rdata,
                                         input logic err);
      bus_view_type v;
      v.phase    = phase;
      v.addr     = addr;
      v.is_write = is_write;
      v.prot     = prot;
      v.strobe   = strobe;
      v.wdata    = wdata;
      v.enable   = enable;
      v.cpl      = cpl;
      v.rdata    = rdata;
      v.err      = err;
      return v;
   endfunction

   function automatic dir_row_type chk(input dir_row_type row, input bus_view_type v);
      row.typed = 1'b1;
      row.view  = v;
      return row;
   endfunction

   function automatic dir_row_type csr_row(input logic [TMO_W-1:0] value);
      dir_row_type row;
      row           = '0;
      row.is_csr    = 1'b1;
      row.csr_value = value;
      return row;
   endfunction

   task automatic load_directed_rows();
      // tick straight out of reset: nothing moves, reset attributes visible
      dir_rows.push_back(chk(xfer(FUNC_TICK, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, '0),
         view(PH_IDLE, '0, 1'b0, '0, '1, '0, 1'b0, CPL_NONE, '0, 1'b0)));
      // read at top address, all protection bits: strobes and wdata latch as zero
      dir_rows.push_back(chk(xfer(FUNC_READ, '1, '1, '1, '1, 1'b0, 1'b0, 1'b0, '0),
         view(PH_SETUP, '1, 1'b0, '1, '0, '0, 1'b0, CPL_NONE, '0, 1'b0)));
      // write while setup is open bounces
      dir_rows.push_back(chk(xfer(FUNC_WRITE, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, '0),
         view(PH_SETUP, '1, 1'b0, '1, '0, '0, 1'b0, CPL_BUSY, '0, 1'b0)));
      dir_rows.push_back(chk(xfer(FUNC_TICK, '0, '0, '0, '0, 1'b1, 1'b0, 1'b0, '0),
         view(PH_ACCESS, '1, 1'b0, '1, '0, '0, 1'b1, CPL_NONE, '0, 1'b0)));
      // read completes clean with all-ones data
      dir_rows.push_back(chk(xfer(FUNC_TICK, '0, '0, '0, '0, 1'b0, 1'b1, 1'b0, '1),
         view(PH_IDLE, '1, 1'b0, '1, '0, '0, 1'b0, CPL_OK, '1, 1'b0)));
      // plain write ignores the strobe field and drives all lanes
      dir_rows.push_back(chk(xfer(FUNC_WRITE, '0, '1, '0, '0, 1'b0, 1'b0, 1'b0, '0),
         view(PH_SETUP, '0, 1'b1, '0, '1, '0, 1'b0, CPL_NONE, '0, 1'b0)));
      // done is meaningless in setup
      dir_rows.push_back(xfer(FUNC_TICK, '1, '0, '0, '0, 1'b0, 1'b1, 1'b1, '1));
      dir_rows.push_back(chk(xfer(FUNC_TICK, '0, '0, '0, '0, 1'b1, 1'b0, 1'b0, '0),
         view(PH_ACCESS, '0, 1'b1, '0, '1, '1, 1'b1, CPL_NONE, '0, 1'b0)));
      // slave error: sticky flag set, read data suppressed
      dir_rows.push_back(chk(xfer(FUNC_TICK, '0, '0, '0, '0, 1'b0, 1'b1, 1'b1, 32'hA5A5_A5A5),
         view(PH_IDLE, '0, 1'b1, '0, '1, '0, 1'b0, CPL_SLVERR, '0, 1'b1)));
      // strobed write with no lanes, a read bounced during access, clean finish clears flag
      dir_rows.push_back(xfer(FUNC_SWRITE, 32'h1234_5678, '0, '0, 3'd2, 1'b0, 1'b0, 1'b0, '0));
      dir_rows.push_back(xfer(FUNC_TICK, '0, '0, '0, '0, 1'b1, 1'b0, 1'b0, '0));
      dir_rows.push_back(xfer(FUNC_READ, '0, '0, '0, '0, 1'b1, 1'b1, 1'b0, '0));
      dir_rows.push_back(xfer(FUNC_TICK, '0, '0, '0, '0, 1'b0, 1'b1, 1'b0, 32'h0BAD_F00D));
      // zero timeout is taken as one tick of grace per wait phase
      dir_rows.push_back(csr_row('0));
      dir_rows.push_back(xfer(FUNC_SWRITE, 32'h8000_0001, 32'h5A5A_5A5A, '1, 3'd5,
                              1'b0, 1'b0, 1'b0, '0));
      dir_rows.push_back(xfer(FUNC_TICK, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, '0));
      // setup timeout
      dir_rows.push_back(chk(xfer(FUNC_TICK, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, '0),
         view(PH_IDLE, 32'h8000_0001, 1'b1, 3'd5, '1, '0, 1'b0, CPL_TIMEOUT, '0, 1'b1)));
      dir_rows.push_back(xfer(FUNC_READ, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, '0));
      dir_rows.push_back(xfer(FUNC_TICK, '0, '0, '0, '0, 1'b1, 1'b0, 1'b0, '0));
      dir_rows.push_back(xfer(FUNC_TICK, '0, '0, '0, '0, 1'b1, 1'b0, 1'b1, '1));
      // access timeout
      dir_rows.push_back(chk(xfer(FUNC_TICK, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, '0),
         view(PH_IDLE, '0, 1'b0, '0, '0, '0, 1'b0, CPL_TIMEOUT, '0, 1'b1)));
      // idle tick with every sampled signal high does nothing
      dir_rows.push_back(xfer(FUNC_TICK, '1, '1, '1, '1, 1'b1, 1'b1, 1'b1, '1));
      // largest timeout, then a clean write
      dir_rows.push_back(csr_row('1));
      dir_rows.push_back(xfer(FUNC_WRITE, 32'hAAAA_AAAA, 32'h5555_5555, 4'h6, 3'd3,
                              1'b0, 1'b0, 1'b0, '0));
      dir_rows.push_back(xfer(FUNC_TICK, '0, '0, '0, '0, 1'b1, 1'b0, 1'b0, '0));
      dir_rows.push_back(xfer(FUNC_TICK, '0, '0, '0, '0, 1'b0, 1'b1, 1'b0, '1));
   endtask

   // ---------------------------------------------------------------------------------------
   // Main sequence: reset, directed table, then random phases, each under its own timeout.
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      apb_req_type      r;
      logic [TMO_W-1:0] tmo;
      int               ready_pct;
      int               done_pct;
      int               req_pct;

      seq_phase   = PH_IDLE;
      seq_wait    = '0;
      seq_timeout = TMO_RESET;
      seq_addr    = '0;
      seq_write   = 1'b0;
      seq_prot    = '0;
      seq_strobe  = '1;
      seq_wdata   = '0;
      seq_err     = 1'b0;
      load_directed_rows();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr)
            write_timeout(dir_rows[i].csr_value);
         else
            drive_transfer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].view);
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         // mostly short timeouts so both wait phases actually expire; extremes included
         case (p)
            0:       tmo = TMO_W'(1);
            1:       tmo = TMO_W'(3);
            2:       tmo = '0;
            3:       tmo = '1;
            4:       tmo = TMO_W'(2);
            5:       tmo = TMO_RESET;
            6:       tmo = TMO_W'($urandom);
            default: tmo = TMO_W'(5);
         endcase
         write_timeout(tmo);
         ready_pct = $urandom_range(15, 90);
         done_pct  = $urandom_range(15, 90);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // one full drain mid-run: sender holds off until nothing is due
            if (p == 2 && n == ITEMS_PER_PHASE / 2) quiesce();
            r        = '0;
            // mostly well-formed: requests from idle, ticks while busy; the rest is noise
            req_pct  = (seq_phase == PH_IDLE) ? 85 : 8;
            r.func   = ($urandom_range(0, 99) < req_pct) ? 2'($urandom_range(1, 3)) : FUNC_TICK;
            case ($urandom_range(0, 7))
               0:       r.addr = '0;
               1:       r.addr = '1;
               default: r.addr = $urandom;
            endcase
            case ($urandom_range(0, 7))
               0:       r.wdata = '0;
               1:       r.wdata = '1;
               default: r.wdata = $urandom;
            endcase
            r.strobe = STRB_W'($urandom_range(0, 15));
            r.prot   = PROT_W'($urandom_range(0, 7));
            r.ready  = ($urandom_range(0, 99) < ready_pct);
            r.done   = ($urandom_range(0, 99) < done_pct);
            r.serr   = ($urandom_range(0, 3) == 0);
            r.rdata  = $urandom;
            drive_transfer(r, 1'b0, '0);
         end
      end

      // drain, then allow the queue and result register to settle
      @(negedge clock);
      req_valid <= 1'b0;
      while (bus_views_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("run: %0d transfers sent, %0d results checked, %0d timeout settings",
               sent_count, checked_count, tmo_writes);
      $display("completions: %0d ok, %0d slave error, %0d timeout, %0d rejected busy",
               ok_count, slverr_count, timeout_count, busy_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
